// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the queue and back-end RTL modules of the distance engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: %m");
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition: %m");
`else
`define ASSERT_PROP(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)
`endif
`endif

// ----- hw/rtl/vde_pkg.sv -----
// Types and constants shared by the distance engine modules.
`timescale 1ns / 1ps

package vde_pkg;

   localparam int COMP_W  = 16;
   localparam int TERM_W  = 48;
   localparam int RAW_W   = 56;
   localparam int DIST_W  = 24;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_METRIC_MODE     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MINKOWSKI_ORDER = 1'b1;

   typedef enum logic [1:0] {
      METRIC_EUCLIDEAN = 2'd0,
      METRIC_MANHATTAN = 2'd1,
      METRIC_CHEBYSHEV = 2'd2,
      METRIC_MINKOWSKI = 2'd3
   } metric_type;

   typedef enum logic {
      OP_SUM = 1'b0,
      OP_MAX = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ROOT_NONE = 2'd0,
      ROOT_SQRT = 2'd1,
      ROOT_CBRT = 2'd2
   } root_type;

   // one classified component pair, as queued between front and back
   typedef struct packed {
      logic [TERM_W-1:0] term;
      op_type            op;
      root_type          root;
      logic              last;
   } q_entry_type;

endpackage

// ----- hw/rtl/vector_distance_engine_top.sv -----
// Vector distance engine: top level tying front end, queue and back end.
`timescale 1ns / 1ps

// Streams one component pair per req transaction (a, b, last flag); on the
// pair flagged last, returns one rsp transaction with the raw total (sum of
// |a-b|^p, or max |a-b| for Chebyshev) and the floor of the matching root.
// Channels use valid/stall; a transaction moves when valid is high and stall
// is low. csr_wr_en writes metric_mode (index 0) or minkowski_order (index 1)
// into its register; write only while no vector is in flight.
// Throughput: one pair per cycle while no root runs and nothing stalls, set
// by the three-stage |a-b| and power pipeline (two multiplies) and the
// saturating accumulate. Manhattan, Chebyshev and order-1 Minkowski results
// load as the last pair is taken; a square root first runs 30 one-bit steps,
// a cube root 20 digits, each through ST_CBRT_A and ST_CBRT_B. While a root
// runs the back end takes no pairs; the queue and front pipeline fill, then req_stall.
// rsp_stall holds the result register; pairs of the next vector still
// accumulate and only its last pair (or finished root) waits for the register.
// Reset (synchronous) empties the pipeline and queue, clears the
// accumulator, and selects Euclidean with Minkowski order 2.
module vector_distance_engine_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [vde_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vde_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [vde_pkg::COMP_W-1:0]   req_component_a,
   input  logic signed [vde_pkg::COMP_W-1:0]   req_component_b,
   input  logic                                req_last_component,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [vde_pkg::DIST_W-1:0]          rsp_distance,
   output logic [vde_pkg::RAW_W-1:0]           rsp_raw_total
);
   import vde_pkg::*;

   logic        q_push, q_full, q_pop, q_valid;
   q_entry_type q_wr_entry, q_rd_entry;

   vde_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_component_a    (req_component_a),
      .req_component_b    (req_component_b),
      .req_last_component (req_last_component),
      .q_push_o           (q_push),
      .q_entry_o          (q_wr_entry),
      .q_full_i           (q_full)
   );

   vde_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (q_push),
      .entry_i (q_wr_entry),
      .full_o  (q_full),
      .pop_i   (q_pop),
      .entry_o (q_rd_entry),
      .valid_o (q_valid)
   );

   vde_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid_i     (q_valid),
      .q_entry_i     (q_rd_entry),
      .q_pop_o       (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_distance  (rsp_distance),
      .rsp_raw_total (rsp_raw_total)
   );

endmodule

// ----- hw/rtl/vde_front.sv -----
// Front end: config registers, transaction intake, |a-b| and power pipeline.
`timescale 1ns / 1ps

module vde_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [vde_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vde_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [vde_pkg::COMP_W-1:0]   req_component_a,
   input  logic signed [vde_pkg::COMP_W-1:0]   req_component_b,
   input  logic                                req_last_component,
   output logic                                q_push_o,
   output vde_pkg::q_entry_type                q_entry_o,
   input  logic                                q_full_i
);
   import vde_pkg::*;

   typedef enum logic [1:0] {
      POW_1 = 2'd0,
      POW_2 = 2'd1,
      POW_3 = 2'd2
   } pow_type;

   metric_type metric_ff, metric_in;
   logic [1:0] order_ff, order_in;

   logic rdy1, rdy2, rdy3;
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;

   logic [COMP_W-1:0]   d1_ff, d2_ff;
   logic [2*COMP_W-1:0] sq2_ff;
   logic [TERM_W-1:0]   term3_ff;
   op_type              op1_ff, op2_ff, op3_ff, op_c;
   root_type            root1_ff, root2_ff, root3_ff, root_c;
   pow_type             pow1_ff, pow2_ff, pow_c;
   logic                last1_ff, last2_ff, last3_ff;

   logic signed [COMP_W:0] diff_c;
   logic [COMP_W:0]        abs_c;
   logic [2*COMP_W-1:0]    sq_c;
   logic [TERM_W-1:0]      term_c;

   // configuration registers
   always_comb begin
      metric_in = metric_ff;
      order_in  = order_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_METRIC_MODE:     metric_in = metric_type'(csr_wdata);
            CSR_MINKOWSKI_ORDER: order_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // metric decode: operation, power of the difference, final root
   always_comb begin
      op_c   = OP_SUM;
      root_c = ROOT_NONE;
      pow_c  = POW_1;
      unique case (metric_ff)
         METRIC_EUCLIDEAN: begin
            pow_c  = POW_2;
            root_c = ROOT_SQRT;
         end
         METRIC_MANHATTAN: ;
         METRIC_CHEBYSHEV: op_c = OP_MAX;
         METRIC_MINKOWSKI: begin
            case (order_ff)
               2'd2: begin
                  pow_c  = POW_2;
                  root_c = ROOT_SQRT;
               end
               2'd3: begin
                  pow_c  = POW_3;
                  root_c = ROOT_CBRT;
               end
               default: ;   // order 0 acts as order 1
            endcase
         end
         default: ;
      endcase
   end

   assign diff_c = {req_component_a[COMP_W-1], req_component_a}
                 - {req_component_b[COMP_W-1], req_component_b};
   assign abs_c  = diff_c[COMP_W] ? (~diff_c + 1'b1) : diff_c;
   assign sq_c   = {{COMP_W{1'b0}}, d1_ff} * {{COMP_W{1'b0}}, d1_ff};

   always_comb begin
      case (pow2_ff)
         POW_3:   term_c = {{COMP_W{1'b0}}, sq2_ff} * {{2*COMP_W{1'b0}}, d2_ff};
         POW_2:   term_c = {{COMP_W{1'b0}}, sq2_ff};
         default: term_c = {{2*COMP_W{1'b0}}, d2_ff};
      endcase
   end

   // three stages, each moves when the one after it has room
   assign rdy3      = !v3_ff || !q_full_i;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= METRIC_EUCLIDEAN;
         order_ff  <= 2'd2;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
      end else begin
         metric_ff <= metric_in;
         order_ff  <= order_in;
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         v3_ff     <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         d1_ff    <= abs_c[COMP_W-1:0];
         op1_ff   <= op_c;
         root1_ff <= root_c;
         pow1_ff  <= pow_c;
         last1_ff <= req_last_component;
      end
      if (rdy2) begin
         d2_ff    <= d1_ff;
         sq2_ff   <= sq_c;
         op2_ff   <= op1_ff;
         root2_ff <= root1_ff;
         pow2_ff  <= pow1_ff;
         last2_ff <= last1_ff;
      end
      if (rdy3) begin
         term3_ff <= term_c;
         op3_ff   <= op2_ff;
         root3_ff <= root2_ff;
         last3_ff <= last2_ff;
      end
   end

   assign q_push_o       = v3_ff && !q_full_i;
   assign q_entry_o.term = term3_ff;
   assign q_entry_o.op   = op3_ff;
   assign q_entry_o.root = root3_ff;
   assign q_entry_o.last = last3_ff;

endmodule

// ----- hw/rtl/vde_queue.sv -----
// Small register FIFO between the front end and the accumulate/root back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vde_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_i,
   input  vde_pkg::q_entry_type entry_i,
   output logic                 full_o,
   input  logic                 pop_i,
   output vde_pkg::q_entry_type entry_o,
   output logic                 valid_o
);
   import vde_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   q_entry_type     mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full_o  = (count_ff == CW'(DEPTH));
   assign valid_o = (count_ff != '0);
   assign entry_o = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= entry_i;
      end
   end

   `ASSERT_NEVER(a_push_full, clock, reset, push_i && full_o)
   `ASSERT_NEVER(a_pop_empty, clock, reset, pop_i && !valid_o)
   `ASSERT_PROP(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))

endmodule

// ----- hw/rtl/vde_back.sv -----
// Back end: saturating sum / running max, digit-serial root, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vde_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid_i,
   input  vde_pkg::q_entry_type                q_entry_i,
   output logic                                q_pop_o,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [vde_pkg::DIST_W-1:0]          rsp_distance,
   output logic [vde_pkg::RAW_W-1:0]           rsp_raw_total
);
   import vde_pkg::*;

   typedef enum logic [4:0] {
      ST_ACC    = 5'b00001,
      ST_SQRT   = 5'b00010,
      ST_CBRT_A = 5'b00100,
      ST_CBRT_B = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   localparam int SRC_W  = 60;   // multiple of both 2 and 3
   localparam int REM_W  = 48;
   localparam int ROOT_W = 28;
   localparam int CY_W   = 19;   // cube root of a 56-bit value
   localparam int YSQ_W  = 2 * CY_W;
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] SQRT_STEPS = 5'd30;
   localparam logic [STEP_W-1:0] CBRT_STEPS = 5'd20;

   state_type            state_ff, state_in;
   logic [RAW_W-1:0]     acc_ff, acc_in, raw_ff, raw_in;
   logic [SRC_W-1:0]     src_ff, src_in;
   logic [REM_W-1:0]     rem_ff, rem_in, trial_ff, trial_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [YSQ_W-1:0]     ysq_ff, ysq_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;
   logic [RAW_W-1:0]     rsp_raw_ff, rsp_raw_in;

   logic                 out_free, rsp_load;
   logic                 in_root_c, root_end_c;
   logic [RAW_W:0]       sum_c;
   logic [RAW_W-1:0]     sat_sum_c, max_c, new_acc_c;
   logic [REM_W-1:0]     sq_rem_c, sq_trial_c, cb_sum_c;
   logic [ROOT_W-1:0]    y2_c;
   logic [YSQ_W-1:0]     ysq4_c;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign sum_c     = {1'b0, acc_ff} + {{(RAW_W + 1 - TERM_W){1'b0}}, q_entry_i.term};
   assign sat_sum_c = sum_c[RAW_W] ? {RAW_W{1'b1}} : sum_c[RAW_W-1:0];
   assign max_c     = ({{(RAW_W - TERM_W){1'b0}}, q_entry_i.term} > acc_ff)
                    ? {{(RAW_W - TERM_W){1'b0}}, q_entry_i.term} : acc_ff;
   assign new_acc_c = (q_entry_i.op == OP_MAX) ? max_c : sat_sum_c;

   // square root digit: bring down two bits, try 4r+1
   assign sq_rem_c   = {rem_ff[REM_W-3:0], src_ff[SRC_W-1 -: 2]};
   assign sq_trial_c = {{(REM_W - ROOT_W - 2){1'b0}}, root_ff, 2'b01};

   // cube root digit: trial is 3*(4r^2 + 2r) + 1
   assign y2_c     = {root_ff[ROOT_W-2:0], 1'b0};
   assign ysq4_c   = {ysq_ff[YSQ_W-3:0], 2'b00};
   assign cb_sum_c = {{(REM_W - YSQ_W){1'b0}}, ysq4_c}
                   + {{(REM_W - CY_W - 1){1'b0}}, root_ff[CY_W-1:0], 1'b0};

   always_comb begin
      state_in    = state_ff;
      acc_in      = acc_ff;
      raw_in      = raw_ff;
      src_in      = src_ff;
      rem_in      = rem_ff;
      trial_in    = trial_ff;
      root_in     = root_ff;
      ysq_in      = ysq_ff;
      step_in     = step_ff;
      q_pop_o     = 1'b0;
      rsp_load    = 1'b0;
      rsp_dist_in = rsp_dist_ff;
      rsp_raw_in  = rsp_raw_ff;

      unique case (state_ff)
         ST_ACC: begin
            if (q_valid_i && (!q_entry_i.last || q_entry_i.root != ROOT_NONE
                              || out_free)) begin
               q_pop_o = 1'b1;
               if (!q_entry_i.last) begin
                  acc_in = new_acc_c;
               end else begin
                  acc_in = '0;
                  if (q_entry_i.root == ROOT_NONE) begin
                     rsp_load    = 1'b1;
                     rsp_raw_in  = new_acc_c;
                     rsp_dist_in = (|new_acc_c[RAW_W-1:DIST_W]) ? {DIST_W{1'b1}}
                                                                : new_acc_c[DIST_W-1:0];
                  end else begin
                     raw_in  = new_acc_c;
                     src_in  = {{(SRC_W - RAW_W){1'b0}}, new_acc_c};
                     rem_in  = '0;
                     root_in = '0;
                     ysq_in  = '0;
                     if (q_entry_i.root == ROOT_SQRT) begin
                        step_in  = SQRT_STEPS;
                        state_in = ST_SQRT;
                     end else begin
                        step_in  = CBRT_STEPS;
                        state_in = ST_CBRT_A;
                     end
                  end
               end
            end
         end
         ST_SQRT: begin
            src_in  = {src_ff[SRC_W-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (sq_rem_c >= sq_trial_c) begin
               rem_in  = sq_rem_c - sq_trial_c;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = sq_rem_c;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_CBRT_A: begin
            rem_in   = {rem_ff[REM_W-4:0], src_ff[SRC_W-1 -: 3]};
            src_in   = {src_ff[SRC_W-4:0], 3'b000};
            trial_in = cb_sum_c + {cb_sum_c[REM_W-2:0], 1'b0} + REM_W'(1);
            state_in = ST_CBRT_B;
         end
         ST_CBRT_B: begin
            step_in = step_ff - 1'b1;
            if (rem_ff >= trial_ff) begin
               rem_in  = rem_ff - trial_ff;
               root_in = y2_c | ROOT_W'(1);
               ysq_in  = ysq4_c + {{(YSQ_W - CY_W - 2){1'b0}}, root_ff[CY_W-1:0], 2'b01};
            end else begin
               root_in = y2_c;
               ysq_in  = ysq4_c;
            end
            state_in = (step_ff == STEP_W'(1)) ? ST_DONE : ST_CBRT_A;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_raw_in  = raw_ff;
               rsp_dist_in = (|root_ff[ROOT_W-1:DIST_W]) ? {DIST_W{1'b1}}
                                                         : root_ff[DIST_W-1:0];
               state_in    = ST_ACC;
            end
         end
         default: state_in = ST_ACC;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      src_ff      <= src_in;
      rem_ff      <= rem_in;
      trial_ff    <= trial_in;
      root_ff     <= root_in;
      ysq_ff      <= ysq_in;
      step_ff     <= step_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_raw_ff  <= rsp_raw_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_dist_ff;
   assign rsp_raw_total = rsp_raw_ff;

   assign in_root_c  = (state_ff == ST_SQRT) || (state_ff == ST_CBRT_A)
                    || (state_ff == ST_CBRT_B);
   assign root_end_c = (state_ff == ST_SQRT) || (state_ff == ST_CBRT_B);

   `ASSERT_NEVER(a_rsp_overwrite, clock, reset, rsp_load && rsp_valid_ff && rsp_stall)
   `ASSERT_PROP(a_acc_clear_root, clock, reset, (state_ff != ST_ACC) |-> (acc_ff == '0))
   `ASSERT_PROP(a_step_live, clock, reset, in_root_c |-> (step_ff != '0))
   `ASSERT_PROP(a_done_from_root, clock, reset, $rose(state_ff == ST_DONE) |-> $past(root_end_c))

endmodule

// ----- tb/vector_distance_engine_top_tb.sv -----
// Testbench for the vector distance engine: streamed pairs checked against a local model.
`timescale 1ns / 1ps
module vector_distance_engine_top_tb;
   import vde_pkg::*;

   localparam longint unsigned RAW_SAT  = (64'd1 << RAW_W) - 64'd1;
   localparam longint unsigned DIST_SAT = (64'd1 << DIST_W) - 64'd1;
   // worst result latency is a cube root; leave margin
   localparam int          SETTLE_CYCLES = 60;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int          RANDOM_PHASES = 16;
   localparam int          PAIRS_PER_PHASE = 20;

   typedef struct {
      logic signed [COMP_W-1:0] a;
      logic signed [COMP_W-1:0] b;
      logic                     last;
   } pair_type;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic [RAW_W-1:0]  raw_total;
   } result_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   logic [CSR_INDEX_W-1:0]         csr_index;
   logic [CSR_DATA_W-1:0]          csr_wdata;
   logic                           req_valid;
   logic                           req_stall;
   logic signed [COMP_W-1:0]       req_component_a;
   logic signed [COMP_W-1:0]       req_component_b;
   logic                           req_last_component;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [DIST_W-1:0]              rsp_distance;
   logic [RAW_W-1:0]               rsp_raw_total;

   pair_type        pending_pairs[$];
   result_type      expected_distances[$];

   metric_type      cur_metric;
   logic [1:0]      cur_order;
   longint unsigned pair_accum;

   int              send_idle_pct;
   int              recv_stall_pct;
   int              rsp_hold_left;
   int              fail_count;
   int              pairs_queued;
   int              pairs_in;
   int              results_checked;
   int              settings_used;
   int unsigned     cycle_count;

   vector_distance_engine_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_component_a    (req_component_a),
      .req_component_b    (req_component_b),
      .req_last_component (req_last_component),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_distance       (rsp_distance),
      .rsp_raw_total      (rsp_raw_total)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned c;
      r = 0;
      for (int b = 28; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   function automatic longint unsigned floor_cbrt(longint unsigned v);
      longint unsigned r;
      longint unsigned c;
      r = 0;
      for (int b = 19; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c * c <= v) r = c;
      end
      return r;
   endfunction

   // fold one accepted pair into the running total; a last pair yields a result
   function automatic void accumulate_pair(logic signed [COMP_W-1:0] a,
                                           logic signed [COMP_W-1:0] b, logic last);
      int              diff;
      longint unsigned mag;
      longint unsigned term;
      longint unsigned dist_val;
      int unsigned     p;
      result_type      res;
      diff = int'(a) - int'(b);
      mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
      p    = 1;
      if (cur_metric == METRIC_EUCLIDEAN) p = 2;
      else if (cur_metric == METRIC_MINKOWSKI) p = (cur_order == 2'd0) ? 1 : cur_order;
      if (cur_metric == METRIC_CHEBYSHEV) begin
         if (mag > pair_accum) pair_accum = mag;
      end else begin
         term = mag;
         if (p >= 2) term = term * mag;
         if (p >= 3) term = term * mag;
         if (pair_accum > RAW_SAT - term) pair_accum = RAW_SAT;
         else pair_accum = pair_accum + term;
      end
      if (last) begin
         if (cur_metric == METRIC_MANHATTAN || cur_metric == METRIC_CHEBYSHEV || p == 1)
            dist_val = pair_accum;
         else if (p == 2) dist_val = floor_sqrt(pair_accum);
         else dist_val = floor_cbrt(pair_accum);
         if (dist_val > DIST_SAT) dist_val = DIST_SAT;
         res.distance  = dist_val[DIST_W-1:0];
         res.raw_total = pair_accum[RAW_W-1:0];
         expected_distances.push_back(res);
         pair_accum = 0;
      end
   endfunction

   function automatic void push_pair(logic signed [COMP_W-1:0] a,
                                     logic signed [COMP_W-1:0] b, logic last);
      pair_type it;
      it.a    = a;
      it.b    = b;
      it.last = last;
      pending_pairs.push_back(it);
      pairs_queued++;
   endfunction

   function automatic logic signed [COMP_W-1:0] rand_component();
      logic signed [COMP_W-1:0] v;
      case ($urandom_range(0, 9))
         6: begin
            case ($urandom_range(0, 3))
               0: v = 16'sh8000;
               1: v = 16'sh7FFF;
               2: v = 16'sh0000;
               default: v = 16'shFFFF;
            endcase
         end
         7: v = COMP_W'(int'($urandom_range(0, 16)) - 8);
         default: v = COMP_W'($urandom);
      endcase
      return v;
   endfunction

   // mostly short vectors, a few long ones
   function automatic int push_random_vector();
      int                       len;
      int                       sel;
      logic signed [COMP_W-1:0] a;
      logic signed [COMP_W-1:0] b;
      sel = $urandom_range(0, 99);
      if (sel < 70) len = $urandom_range(1, 6);
      else if (sel < 99) len = $urandom_range(7, 32);
      else len = $urandom_range(100, 256);
      for (int i = 0; i < len; i++) begin
         a = rand_component();
         case ($urandom_range(0, 9))
            0: b = a;
            1: b = ~a;
            default: b = rand_component();
         endcase
         push_pair(a, b, i == len - 1);
      end
      return len;
   endfunction

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_METRIC_MODE) cur_metric = metric_type'(data);
      else cur_order = data;
   endtask

   task automatic set_config(metric_type metric, logic [1:0] order);
      write_csr(CSR_METRIC_MODE, metric);
      write_csr(CSR_MINKOWSKI_ORDER, order);
      settings_used++;
   endtask

   // every queued pair taken, every result back, then let the back end settle
   task automatic wait_idle();
      while (pairs_in != pairs_queued || expected_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // driver: predict on acceptance, then offer the next pair or idle
   always @(posedge clock) begin
      pair_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            accumulate_pair(req_component_a, req_component_b, req_last_component);
            pairs_in++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               it = pending_pairs.pop_front();
               req_valid          <= 1'b1;
               req_component_a    <= it.a;
               req_component_b    <= it.b;
               req_last_component <= it.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result transaction against the oldest expectation
   always @(posedge clock) begin
      result_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_distances.size() == 0) begin
               $error("unexpected result: distance %0d raw_total %0d",
                      rsp_distance, rsp_raw_total);
               fail_count++;
            end else begin
               exp_r = expected_distances.pop_front();
               results_checked++;
               if (rsp_distance !== exp_r.distance) begin
                  $error("distance mismatch: expected %0d, actual %0d",
                         exp_r.distance, rsp_distance);
                  fail_count++;
               end
               if (rsp_raw_total !== exp_r.raw_total) begin
                  $error("raw_total mismatch: expected %0d, actual %0d",
                         exp_r.raw_total, rsp_raw_total);
                  fail_count++;
               end
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_distances.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int n;
      clock              = 1'b0;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_valid          = 1'b0;
      req_component_a    = '0;
      req_component_b    = '0;
      req_last_component = 1'b0;
      rsp_stall          = 1'b0;
      cur_metric         = METRIC_EUCLIDEAN;
      cur_order          = 2'd2;
      pair_accum         = 0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      rsp_hold_left      = 0;
      fail_count         = 0;
      pairs_queued       = 0;
      pairs_in           = 0;
      results_checked    = 0;
      settings_used      = 1;
      cycle_count        = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: Euclidean
      push_pair(16'sh7FFF, 16'sh8000, 1'b1);
      wait_idle();
      set_config(METRIC_EUCLIDEAN, 2'd3);
      push_pair(16'sh8000, 16'sh7FFF, 1'b1);
      push_pair(16'sd0, 16'sd0, 1'b1);
      push_pair(16'sd3, -16'sd1, 1'b0);
      push_pair(-16'sd7, 16'sd2, 1'b0);
      push_pair(16'sd5, 16'sd5, 1'b1);
      wait_idle();
      set_config(METRIC_MANHATTAN, 2'd0);
      push_pair(16'sh7FFF, 16'sh8000, 1'b0);
      push_pair(16'sh8000, 16'sh7FFF, 1'b0);
      push_pair(16'sd1, -16'sd1, 1'b1);
      wait_idle();
      set_config(METRIC_CHEBYSHEV, 2'd1);
      push_pair(16'sd10, -16'sd10, 1'b0);
      push_pair(16'sh8000, 16'sh7FFF, 1'b0);
      push_pair(16'sd0, 16'sd1, 1'b1);
      push_pair(-16'sd1, -16'sd1, 1'b1);
      wait_idle();
      // order zero behaves as order one
      set_config(METRIC_MINKOWSKI, 2'd0);
      push_pair(16'sd4, -16'sd4, 1'b0);
      push_pair(-16'sd3, 16'sd0, 1'b1);
      wait_idle();
      set_config(METRIC_MINKOWSKI, 2'd1);
      push_pair(16'sh7FFF, 16'sh8000, 1'b1);
      wait_idle();
      set_config(METRIC_MINKOWSKI, 2'd2);
      push_pair(16'sd3, 16'sd0, 1'b0);
      push_pair(16'sd0, 16'sd4, 1'b1);
      wait_idle();
      set_config(METRIC_MINKOWSKI, 2'd3);
      push_pair(16'sh7FFF, 16'sh8000, 1'b0);
      push_pair(16'sd2, 16'sd0, 1'b1);
      push_pair(16'sh8000, 16'sh8000, 1'b1);
      wait_idle();
      // registers change partway through a vector
      set_config(METRIC_EUCLIDEAN, 2'd2);
      push_pair(16'sd100, -16'sd100, 1'b0);
      push_pair(16'sd7, 16'sd3, 1'b0);
      wait_idle();
      set_config(METRIC_MANHATTAN, 2'd2);
      push_pair(16'sd1, 16'sd9, 1'b1);
      wait_idle();

      // cubes of the largest difference past the dimension bound: raw total saturates
      set_config(METRIC_MINKOWSKI, 2'd3);
      for (int i = 0; i < 260; i++) push_pair(16'sh7FFF, 16'sh8000, i == 259);
      wait_idle();
      // same length in Manhattan: distance clips at its maximum
      set_config(METRIC_MANHATTAN, 2'd1);
      for (int i = 0; i < 260; i++) push_pair(16'sh8000, 16'sh7FFF, i == 259);
      wait_idle();

      // long receiver hold while pairs keep coming, so the input backs up
      set_config(METRIC_MINKOWSKI, 2'd3);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      rsp_hold_left  = 400;
      n = 0;
      while (n < 60) n += push_random_vector();
      // sender pauses until every result is back
      while (pairs_in != pairs_queued || expected_distances.size() != 0) @(posedge clock);
      n = 0;
      while (n < 24) n += push_random_vector();
      wait_idle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_config(metric_type'(ph % 4), 2'($urandom_range(0, 3)));
         case (ph / 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         n = 0;
         while (n < PAIRS_PER_PHASE) n += push_random_vector();
         wait_idle();
      end

      $display("checked %0d distance results from %0d component pairs over %0d settings,",
               results_checked, pairs_in, settings_used);
      $display("with saturation, order zero, a mid-vector change and backpressure");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- vector_distance_engine_top.f -----
+incdir+hw/rtl
hw/rtl/vde_pkg.sv
hw/rtl/vde_front.sv
hw/rtl/vde_queue.sv
hw/rtl/vde_back.sv
hw/rtl/vector_distance_engine_top.sv
tb/vector_distance_engine_top_tb.sv
